// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the handle table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("handle table assertion failed");
`define TH_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("handle table assertion failed");
`else
`define TH_ASSERT(lbl, clk, rst, prop)
`define TH_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/thtr_pkg.sv =====
// Types and codes of the tagged handle table.
// Depends on nothing; used by the top level, front end, queue and back end.
package thtr_pkg;

   localparam logic [2:0] MODE_ALLOC  = 3'd0;
   localparam logic [2:0] MODE_FREE   = 3'd1;
   localparam logic [2:0] MODE_EXISTS = 3'd2;
   localparam logic [2:0] MODE_READ   = 3'd3;
   localparam logic [2:0] MODE_WRITE  = 3'd4;
   localparam logic [2:0] MODE_INC    = 3'd5;
   localparam logic [2:0] MODE_DEC    = 3'd6;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BAD   = 3'd1;
   localparam logic [2:0] ST_NOKEY = 3'd2;
   localparam logic [2:0] ST_REFS  = 3'd3;
   localparam logic [2:0] ST_OVF   = 3'd4;
   localparam logic [2:0] ST_FULL  = 3'd5;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      K_ALLOC, K_FREE, K_EXISTS, K_READ, K_WRITE, K_INC, K_DEC, K_REJECT
   } cmd_kind_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_SCAN_RD, S_SCAN_CHK, S_OUT
   } bk_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  idx;
      logic [31:0]  htag;
      logic [31:0]  new_tag;
      logic [63:0]  ident_0;
      logic [63:0]  ident_1;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] new_handle;
      logic        exists_flag;
      logic [63:0] ident_out_0;
      logic [63:0] ident_out_1;
   } rsp_data_type;

endpackage

// ===== rtl/core/thtr_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface thtr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [63:0] handle;
   logic [31:0] new_tag;
   logic [63:0] ident_0;
   logic [63:0] ident_1;
   modport source (output valid, mode, handle, new_tag, ident_0, ident_1, input ready);
   modport sink   (input valid, mode, handle, new_tag, ident_0, ident_1, output ready);
endinterface

interface thtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] new_handle;
   logic        exists_flag;
   logic [63:0] ident_out_0;
   logic [63:0] ident_out_1;
   modport source (output valid, status, new_handle, exists_flag, ident_out_0,
                   ident_out_1, input ready);
   modport sink   (input valid, status, new_handle, exists_flag, ident_out_0,
                   ident_out_1, output ready);
endinterface

// ===== rtl/core/tagged_handle_table_with_refcount_top.sv =====
// Top level of the tagged handle table with reference counts.
// Depends on thtr_pkg, thtr_if, thtr_front, thtr_queue and thtr_back.
//
//   channel   direction  payload
//   req_bus   in         mode, handle, new_tag, ident_0, ident_1
//   rsp_bus   out        status, new_handle, exists_flag, ident_out_0, ident_out_1
//
// In the back end an item passes through command pop with store read,
// execute with write back, and result hand-off to the output register.
// A successful allocate also scans for the next free entry, checking one
// entry at a time. After reset a clearing pass zeroes the stores; no item
// is accepted until it ends. A two-entry command queue and the output
// register let requests be taken while a result waits on the response side.
module tagged_handle_table_with_refcount_top import thtr_pkg::*; #(
   parameter int ENTRIES  = 256,
   parameter int ID_WORDS = 2
) (
   input logic        clock,
   input logic        reset,
   thtr_req_if.sink   req_bus,
   thtr_rsp_if.source rsp_bus
);
   logic    push, pop, q_full, q_empty, init_done;
   cmd_type push_cmd, head;

   thtr_front #(.ENTRIES(ENTRIES)) u_front (
      .req_bus(req_bus), .init_done(init_done), .q_full(q_full),
      .push(push), .cmd(push_cmd));

   thtr_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd),
      .pop(pop), .head(head), .full(q_full), .empty(q_empty));

   thtr_back #(.ENTRIES(ENTRIES), .ID_WORDS(ID_WORDS)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_head(head),
      .q_pop(pop), .init_done(init_done), .rsp_bus(rsp_bus));
endmodule

// ===== rtl/core/thtr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module thtr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/core/thtr_front.sv =====
// Front end: accepts request items and classifies them into commands.
// Depends on thtr_pkg and thtr_req_if.
module thtr_front import thtr_pkg::*; #(
   parameter int ENTRIES = 256
) (
   thtr_req_if.sink  req_bus,
   input  logic      init_done,
   input  logic      q_full,
   output logic      push,
   output cmd_type   cmd
);
   logic idx_ok;

   assign req_bus.ready = init_done && !q_full;
   assign push = req_bus.valid && req_bus.ready;
   assign idx_ok = req_bus.handle[31:0] < 32'(ENTRIES);

   always_comb begin
      cmd.idx     = req_bus.handle[31:0];
      cmd.htag    = req_bus.handle[63:32];
      cmd.new_tag = req_bus.new_tag;
      cmd.ident_0 = req_bus.ident_0;
      cmd.ident_1 = req_bus.ident_1;
      if (req_bus.mode == MODE_ALLOC) begin
         cmd.kind = K_ALLOC;
      end else if (!idx_ok) begin
         cmd.kind = K_REJECT;
      end else begin
         unique case (req_bus.mode)
            MODE_FREE:   cmd.kind = K_FREE;
            MODE_EXISTS: cmd.kind = K_EXISTS;
            MODE_READ:   cmd.kind = K_READ;
            MODE_WRITE:  cmd.kind = K_WRITE;
            MODE_INC:    cmd.kind = K_INC;
            MODE_DEC:    cmd.kind = K_DEC;
            default:     cmd.kind = K_REJECT;
         endcase
      end
   end
endmodule

// ===== rtl/core/thtr_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on thtr_pkg.
module thtr_queue import thtr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

// ===== rtl/core/thtr_back.sv =====
// Back end: executes commands against the tag, count and identifier stores.
// Depends on thtr_pkg, thtr_rsp_if, thtr_ram and assert_macros.svh.
`include "assert_macros.svh"
module thtr_back import thtr_pkg::*; #(
   parameter int ENTRIES  = 256,
   parameter int ID_WORDS = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    q_head,
   output logic       q_pop,
   output logic       init_done,
   thtr_rsp_if.source rsp_bus
);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int FP_W  = $clog2(ENTRIES + 1);
   localparam int IDW   = 64 * ID_WORDS;

   bk_state_type     state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [FP_W-1:0]  fp_ff, fp_in;
   logic [FP_W-1:0]  scan_ff, scan_in;
   cmd_type          cmd_ff, cmd_in;
   rsp_data_type     res_ff, res_in;
   rsp_data_type     out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic             tag_we, cnt_we, id_we;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [31:0]      tag_wdata, cnt_wdata, tag_rd, cnt_rd;
   logic [IDW-1:0]   id_wdata, id_rd;

   logic [IDX_W-1:0] idx;
   logic             live, full, alloc_ok, out_free;
   logic [FP_W-1:0]  alloc_nx, scan_nx;
   logic [31:0]      cnt_dec;
   logic [127:0]     id_words;

   thtr_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tag_ram (
      .clock(clock), .we(tag_we), .waddr(wr_addr), .wdata(tag_wdata),
      .raddr(rd_addr), .rdata(tag_rd));
   thtr_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_cnt_ram (
      .clock(clock), .we(cnt_we), .waddr(wr_addr), .wdata(cnt_wdata),
      .raddr(rd_addr), .rdata(cnt_rd));
   thtr_ram #(.WIDTH(IDW), .DEPTH(ENTRIES)) u_id_ram (
      .clock(clock), .we(id_we), .waddr(wr_addr), .wdata(id_wdata),
      .raddr(rd_addr), .rdata(id_rd));

   assign idx       = cmd_ff.idx[IDX_W-1:0];
   assign live      = (tag_rd != '0) && (tag_rd == cmd_ff.htag);
   assign full      = fp_ff == FP_W'(ENTRIES);
   assign alloc_ok  = !full && (cmd_ff.new_tag != '0);
   assign alloc_nx  = fp_ff + FP_W'(1);
   assign scan_nx   = scan_ff + FP_W'(1);
   assign cnt_dec   = (cnt_rd != '0) ? cnt_rd - 32'd1 : '0;
   assign id_words  = {cmd_ff.ident_1, cmd_ff.ident_0};
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign init_done = state_ff != S_CLEAR;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == IDX_W'(ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!q_empty) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd_ff.kind == K_ALLOC && alloc_ok && alloc_nx != FP_W'(ENTRIES)) begin
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (tag_rd != '0 && scan_nx != FP_W'(ENTRIES)) state_in = S_SCAN_RD;
            else state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      tag_we       = 1'b0;
      cnt_we       = 1'b0;
      id_we        = 1'b0;
      wr_addr      = idx;
      tag_wdata    = '0;
      cnt_wdata    = '0;
      id_wdata     = '0;
      rd_addr      = '0;
      clr_in       = clr_ff;
      fp_in        = fp_ff;
      scan_in      = scan_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         S_CLEAR: begin
            tag_we  = 1'b1;
            cnt_we  = 1'b1;
            id_we   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         S_IDLE: begin
            q_pop   = !q_empty;
            rd_addr = q_head.idx[IDX_W-1:0];
            cmd_in  = q_head;
         end
         S_EXEC: begin
            res_in = '0;
            unique case (cmd_ff.kind)
               K_ALLOC: begin
                  if (full) begin
                     res_in.status = ST_FULL;
                  end else if (!alloc_ok) begin
                     res_in.status = ST_BAD;
                  end else begin
                     tag_we    = 1'b1;
                     cnt_we    = 1'b1;
                     id_we     = 1'b1;
                     wr_addr   = fp_ff[IDX_W-1:0];
                     tag_wdata = cmd_ff.new_tag;
                     id_wdata  = id_words[IDW-1:0];
                     res_in.new_handle = {cmd_ff.new_tag, 32'(fp_ff)};
                     scan_in   = alloc_nx;
                     if (alloc_nx == FP_W'(ENTRIES)) fp_in = alloc_nx;
                  end
               end
               K_REJECT: res_in.status = ST_BAD;
               K_EXISTS: res_in.exists_flag = live;
               default: begin
                  if (!live) begin
                     res_in.status = ST_NOKEY;
                  end else begin
                     unique case (cmd_ff.kind)
                        K_FREE: begin
                           if (cnt_rd != '0) begin
                              res_in.status = ST_REFS;
                           end else begin
                              tag_we = 1'b1;
                              cnt_we = 1'b1;
                              id_we  = 1'b1;
                              if (FP_W'(idx) < fp_ff) fp_in = FP_W'(idx);
                           end
                        end
                        K_READ: begin
                           res_in.ident_out_0 = id_rd[63:0];
                           res_in.ident_out_1 = (ID_WORDS > 1) ? id_rd[IDW-1 -: 64] : '0;
                        end
                        K_WRITE: begin
                           id_we    = 1'b1;
                           id_wdata = id_words[IDW-1:0];
                        end
                        K_INC: begin
                           if (cnt_rd == COUNT_MAX) begin
                              res_in.status = ST_OVF;
                           end else begin
                              cnt_we    = 1'b1;
                              cnt_wdata = cnt_rd + 32'd1;
                           end
                        end
                        default: begin
                           cnt_we    = 1'b1;
                           cnt_wdata = cnt_dec;
                           if (cnt_dec == '0) begin
                              tag_we = 1'b1;
                              id_we  = 1'b1;
                              if (FP_W'(idx) < fp_ff) fp_in = FP_W'(idx);
                           end
                        end
                     endcase
                  end
               end
            endcase
         end
         S_SCAN_RD: begin
            rd_addr = scan_ff[IDX_W-1:0];
         end
         S_SCAN_CHK: begin
            if (tag_rd == '0) begin
               fp_in = scan_ff;
            end else begin
               scan_in = scan_nx;
               if (scan_nx == FP_W'(ENTRIES)) fp_in = scan_nx;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fp_ff        <= fp_in;
         out_valid_ff <= out_valid_in;
      end
      scan_ff <= scan_in;
      cmd_ff  <= cmd_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_ff.status;
   assign rsp_bus.new_handle  = out_ff.new_handle;
   assign rsp_bus.exists_flag = out_ff.exists_flag;
   assign rsp_bus.ident_out_0 = out_ff.ident_out_0;
   assign rsp_bus.ident_out_1 = out_ff.ident_out_1;

   `TH_ASSERT(a_fp_range, clock, reset, fp_ff <= FP_W'(ENTRIES))
   `TH_ASSERT(a_we_state, clock, reset, (tag_we || cnt_we || id_we) |-> (state_ff == S_CLEAR || state_ff == S_EXEC))
   `TH_ASSERT(a_exec_order, clock, reset, (state_ff == S_EXEC) |-> ($past(state_ff) == S_IDLE))
   `TH_ASSERT(a_rsp_source, clock, reset, $rose(out_valid_ff) |-> ($past(state_ff) == S_OUT))
endmodule
